@@ sv/assert_macros.svh @@
// Assertion helpers included by the top unit of the text cell classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check, disabled while reset is asserted.
`define PTC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property check failed");

// Same-cycle implication built on the plain check.
`define PTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  `PTC_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

@@ sv/ptc_pkg.sv @@
package ptc_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [9:0]  sum_t;
  typedef logic [9:0]  dev_t;
  typedef logic [21:0] luma_t;
  typedef logic [3:0]  level_t;
  typedef logic [2:0]  glyph_t;
  typedef logic [3:0]  colour_t;
  typedef logic [1:0]  sel_t;
  typedef logic [3:0]  pidx_t;
  typedef logic [8:0]  shade_t;

  // Glyph codes.
  localparam glyph_t GLYPH_SPACE   = 3'd0;
  localparam glyph_t GLYPH_QUARTER = 3'd1;
  localparam glyph_t GLYPH_HALF    = 3'd2;
  localparam glyph_t GLYPH_THREEQ  = 3'd3;
  localparam glyph_t GLYPH_SOLID   = 3'd4;

  // Console palette indexes.
  localparam colour_t COL_BLACK        = 4'd0;
  localparam colour_t COL_DARK_BLUE    = 4'd1;
  localparam colour_t COL_DARK_GREEN   = 4'd2;
  localparam colour_t COL_DARK_CYAN    = 4'd3;
  localparam colour_t COL_DARK_RED     = 4'd4;
  localparam colour_t COL_DARK_MAGENTA = 4'd5;
  localparam colour_t COL_DARK_YELLOW  = 4'd6;
  localparam colour_t COL_GREY         = 4'd7;
  localparam colour_t COL_DARK_GREY    = 4'd8;
  localparam colour_t COL_BLUE         = 4'd9;
  localparam colour_t COL_GREEN        = 4'd10;
  localparam colour_t COL_CYAN         = 4'd11;
  localparam colour_t COL_RED          = 4'd12;
  localparam colour_t COL_MAGENTA      = 4'd13;
  localparam colour_t COL_YELLOW       = 4'd14;
  localparam colour_t COL_WHITE        = 4'd15;

  // Primary and secondary selectors.
  localparam sel_t PRIM_R = 2'd0;
  localparam sel_t PRIM_G = 2'd1;
  localparam sel_t PRIM_B = 2'd2;
  localparam sel_t SEC_Y  = 2'd0;
  localparam sel_t SEC_C  = 2'd1;
  localparam sel_t SEC_M  = 2'd2;

  localparam int   NUM_PAIRINGS = 9;
  localparam dev_t FLAT_LIMIT   = 10'd7;

  // Glyph thresholds on the shading level (0..510).
  localparam shade_t SHADE_Q1 = 9'd102;
  localparam shade_t SHADE_Q2 = 9'd204;
  localparam shade_t SHADE_Q3 = 9'd306;
  localparam shade_t SHADE_Q4 = 9'd408;
  localparam shade_t SHADE_OFFSET = 9'd255;

  // Luma weights, scaled by 10000.
  localparam luma_t LUMA_WR = 22'd2987;
  localparam luma_t LUMA_WG = 22'd5870;
  localparam luma_t LUMA_WB = 22'd1140;

  // Gray level k is reached when luma >= ceil(k * 2550000 / 13).
  localparam int NUM_LEVELS = 12;
  localparam luma_t LUMA_STEP [NUM_LEVELS] = '{
    luma_t'((1  * 2550000 + 12) / 13), luma_t'((2  * 2550000 + 12) / 13),
    luma_t'((3  * 2550000 + 12) / 13), luma_t'((4  * 2550000 + 12) / 13),
    luma_t'((5  * 2550000 + 12) / 13), luma_t'((6  * 2550000 + 12) / 13),
    luma_t'((7  * 2550000 + 12) / 13), luma_t'((8  * 2550000 + 12) / 13),
    luma_t'((9  * 2550000 + 12) / 13), luma_t'((10 * 2550000 + 12) / 13),
    luma_t'((11 * 2550000 + 12) / 13), luma_t'((12 * 2550000 + 12) / 13)
  };

  typedef struct packed {
    sel_t    prim;
    sel_t    sec;
    colour_t fg_bright;
    colour_t fg_dark;
    colour_t bg_bright;
    colour_t bg_dark;
  } pair_t;

  // Pairings in evaluation order; a later match overrides an earlier one.
  localparam pair_t PAIRINGS [NUM_PAIRINGS] = '{
    '{PRIM_R, SEC_Y, COL_RED,   COL_DARK_RED,   COL_YELLOW,  COL_DARK_YELLOW},
    '{PRIM_R, SEC_M, COL_RED,   COL_DARK_RED,   COL_MAGENTA, COL_DARK_MAGENTA},
    '{PRIM_R, SEC_C, COL_RED,   COL_DARK_RED,   COL_CYAN,    COL_DARK_CYAN},
    '{PRIM_G, SEC_Y, COL_GREEN, COL_DARK_GREEN, COL_YELLOW,  COL_DARK_YELLOW},
    '{PRIM_G, SEC_C, COL_GREEN, COL_DARK_GREEN, COL_CYAN,    COL_DARK_CYAN},
    '{PRIM_G, SEC_M, COL_GREEN, COL_DARK_GREEN, COL_MAGENTA, COL_DARK_MAGENTA},
    '{PRIM_B, SEC_M, COL_BLUE,  COL_DARK_BLUE,  COL_MAGENTA, COL_DARK_MAGENTA},
    '{PRIM_B, SEC_C, COL_BLUE,  COL_DARK_BLUE,  COL_CYAN,    COL_DARK_CYAN},
    '{PRIM_B, SEC_Y, COL_BLUE,  COL_DARK_BLUE,  COL_YELLOW,  COL_DARK_YELLOW}
  };

  // First front stage: channel values, secondaries, sums and luma.
  typedef struct packed {
    logic             grey;
    chan_t [2:0]      pv;
    chan_t [2:0]      sv;
    sum_t             ps;
    sum_t             ss;
    luma_t            luma;
  } s1_t;

  // Second front stage: deviations and gray level.
  typedef struct packed {
    logic             grey;
    chan_t [2:0]      pv;
    chan_t [2:0]      sv;
    dev_t  [2:0]      pd;
    dev_t  [2:0]      sd;
    level_t           level;
  } s2_t;

  // Selection stage: winning pairing and finished gray cell.
  typedef struct packed {
    logic    grey;
    logic    colour_set;
    logic    flat;
    chan_t   c1;
    chan_t   c2;
    pidx_t   idx;
    glyph_t  g_glyph;
    colour_t g_fg;
    colour_t g_bg;
  } s3_t;

  function automatic chan_t umin(chan_t a, chan_t b);
    return (a < b) ? a : b;
  endfunction

  // |3v - s|, the deviation from the mean scaled by three.
  function automatic dev_t absdev(chan_t v, sum_t s);
    sum_t t;
    t = {2'b00, v} + {1'b0, v, 1'b0};
    return (t >= s) ? dev_t'(t - s) : dev_t'(s - t);
  endfunction

  function automatic dev_t max3(dev_t [2:0] a);
    dev_t m;
    m = a[0];
    if (a[1] > m) m = a[1];
    if (a[2] > m) m = a[2];
    return m;
  endfunction

endpackage

@@ sv/ptc_pixel_if.sv @@
interface ptc_pixel_if;
  logic           valid;
  logic           ready;
  ptc_pkg::chan_t red;
  ptc_pkg::chan_t green;
  ptc_pkg::chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ sv/ptc_cell_if.sv @@
interface ptc_cell_if;
  logic             valid;
  logic             ready;
  ptc_pkg::glyph_t  glyph;
  ptc_pkg::colour_t fore_colour;
  ptc_pkg::colour_t back_colour;

  modport source (output valid, output glyph, output fore_colour, output back_colour,
                  input ready);
  modport sink   (input valid, input glyph, input fore_colour, input back_colour,
                  output ready);
endinterface

@@ sv/pixel_to_text_cell_classifier_unit.sv @@
// Turns one RGB pixel beat into one text cell beat (shade glyph, foreground and
// background palette index). A pixel is taken in every clock that the input is ready
// and its cell leaves through two front stages (sums and luma, then deviations and gray
// level), a pairing selection stage and the output register. Every stage holds
// its own valid bit, so a stalled output only backs up the stages behind it
// while any bubble in front of it is still filled. The grey_mode register
// (write cfg_we_i with cfg_wdata_i) selects color or gray classification and
// is sampled as each pixel enters; change it only while no pixels are in flight.
`include "assert_macros.svh"

module pixel_to_text_cell_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  ptc_pixel_if.sink   pix_i,
  ptc_cell_if.source  cell_o
);

  logic         grey_mode_q;
  logic         fr_valid, fr_ready, sel_valid, sel_ready;
  ptc_pkg::s2_t fr_data;
  ptc_pkg::s3_t sel_data;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grey_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      grey_mode_q <= cfg_wdata_i;
    end
  end

  ptc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pix_i.valid),
    .ready_o     (pix_i.ready),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .grey_mode_i (grey_mode_q),
    .valid_o     (fr_valid),
    .ready_i     (fr_ready),
    .data_o      (fr_data)
  );

  ptc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .data_o  (sel_data)
  );

  ptc_cell u_cell (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sel_valid),
    .ready_o       (sel_ready),
    .data_i        (sel_data),
    .valid_o       (cell_o.valid),
    .ready_i       (cell_o.ready),
    .glyph_o       (cell_o.glyph),
    .fore_colour_o (cell_o.fore_colour),
    .back_colour_o (cell_o.back_colour)
  );

  // A delivered glyph is always one of the five shades.
  `PTC_ASSERT_IMPLY(a_glyph_range, clk_i, rst_ni, cell_o.valid,
                    cell_o.glyph <= ptc_pkg::GLYPH_SOLID)

  // Gray cells only share a color when black on black with a solid glyph.
  `PTC_ASSERT_IMPLY(a_grey_same, clk_i, rst_ni,
                    cell_o.valid && grey_mode_q && cell_o.fore_colour == cell_o.back_colour,
                    cell_o.fore_colour == ptc_pkg::COL_BLACK &&
                    cell_o.glyph == ptc_pkg::GLYPH_SOLID)

  // A color cell with black foreground is the unset half-shade cell.
  `PTC_ASSERT_IMPLY(a_colour_unset, clk_i, rst_ni,
                    cell_o.valid && !grey_mode_q && cell_o.fore_colour == ptc_pkg::COL_BLACK,
                    cell_o.back_colour == ptc_pkg::COL_BLACK &&
                    cell_o.glyph == ptc_pkg::GLYPH_HALF)

endmodule

@@ sv/ptc_front.sv @@
module ptc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ptc_pkg::chan_t red_i,
  input  ptc_pkg::chan_t green_i,
  input  ptc_pkg::chan_t blue_i,
  input  logic           grey_mode_i,
  output logic           valid_o,
  input  logic           ready_i,
  output ptc_pkg::s2_t   data_o
);

  ptc_pkg::s1_t s1_d, s1_q;
  ptc_pkg::s2_t s2_d, s2_q;
  logic         s1_valid_q, s2_valid_q;
  logic         s1_ready, s2_ready;

  // Each stage moves when it is empty or its beat leaves downstream.
  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;
  assign valid_o  = s2_valid_q;
  assign data_o   = s2_q;

  // Stage one: secondaries, channel sums and weighted luma.
  always_comb begin
    s1_d.grey  = grey_mode_i;
    s1_d.pv[0] = red_i;
    s1_d.pv[1] = green_i;
    s1_d.pv[2] = blue_i;
    s1_d.sv[0] = ptc_pkg::umin(red_i, green_i);
    s1_d.sv[1] = ptc_pkg::umin(green_i, blue_i);
    s1_d.sv[2] = ptc_pkg::umin(blue_i, red_i);
    s1_d.ps    = ptc_pkg::sum_t'(red_i) + ptc_pkg::sum_t'(green_i)
               + ptc_pkg::sum_t'(blue_i);
    s1_d.ss    = ptc_pkg::sum_t'(s1_d.sv[0]) + ptc_pkg::sum_t'(s1_d.sv[1])
               + ptc_pkg::sum_t'(s1_d.sv[2]);
    s1_d.luma  = ptc_pkg::luma_t'(red_i) * ptc_pkg::LUMA_WR
               + ptc_pkg::luma_t'(green_i) * ptc_pkg::LUMA_WG
               + ptc_pkg::luma_t'(blue_i) * ptc_pkg::LUMA_WB;
  end

  // Stage two: deviations from the means and the grey level.
  always_comb begin
    s2_d.grey  = s1_q.grey;
    s2_d.pv    = s1_q.pv;
    s2_d.sv    = s1_q.sv;
    s2_d.level = '0;
    for (int i = 0; i < 3; i++) begin
      s2_d.pd[i] = ptc_pkg::absdev(s1_q.pv[i], s1_q.ps);
      s2_d.sd[i] = ptc_pkg::absdev(s1_q.sv[i], s1_q.ss);
    end
    for (int k = 0; k < ptc_pkg::NUM_LEVELS; k++) begin
      if (s1_q.luma >= ptc_pkg::LUMA_STEP[k]) s2_d.level = ptc_pkg::level_t'(k + 1);
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload registers load only with a live beat.
  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) s1_q <= s1_d;
    if (s1_valid_q && s2_ready) s2_q <= s2_d;
  end

endmodule

@@ sv/ptc_select.sv @@
module ptc_select (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  ptc_pkg::s2_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output ptc_pkg::s3_t data_o
);

  ptc_pkg::s3_t     s3_d, s3_q;
  logic             s3_valid_q;
  ptc_pkg::dev_t    pmax, smax;
  ptc_pkg::sel_t    prim_sel, sec_sel;
  ptc_pkg::level_t  lm1;

  assign ready_o = !s3_valid_q || ready_i;
  assign valid_o = s3_valid_q;
  assign data_o  = s3_q;

  // Largest deviations and the last pairing that reaches both.
  always_comb begin
    pmax     = ptc_pkg::max3(data_i.pd);
    smax     = ptc_pkg::max3(data_i.sd);
    s3_d.idx = '0;
    prim_sel = ptc_pkg::PAIRINGS[0].prim;
    sec_sel  = ptc_pkg::PAIRINGS[0].sec;
    for (int i = 0; i < ptc_pkg::NUM_PAIRINGS; i++) begin
      if (data_i.pd[ptc_pkg::PAIRINGS[i].prim] == pmax &&
          data_i.sd[ptc_pkg::PAIRINGS[i].sec] == smax) begin
        s3_d.idx = ptc_pkg::pidx_t'(i);
        prim_sel = ptc_pkg::PAIRINGS[i].prim;
        sec_sel  = ptc_pkg::PAIRINGS[i].sec;
      end
    end
    s3_d.grey       = data_i.grey;
    s3_d.colour_set = (pmax >= smax);
    s3_d.flat       = (smax <= ptc_pkg::FLAT_LIMIT);
    s3_d.c1         = data_i.pv[prim_sel];
    s3_d.c2         = data_i.sv[sec_sel];

    // Gray cell: three groups of four shades above the black level.
    lm1 = data_i.level - ptc_pkg::level_t'(1);
    s3_d.g_glyph = ptc_pkg::glyph_t'(lm1[1:0]) + ptc_pkg::GLYPH_QUARTER;
    case (lm1[3:2])
      2'd0: begin
        s3_d.g_fg = ptc_pkg::COL_DARK_GREY;
        s3_d.g_bg = ptc_pkg::COL_BLACK;
      end
      2'd1: begin
        s3_d.g_fg = ptc_pkg::COL_GREY;
        s3_d.g_bg = ptc_pkg::COL_DARK_GREY;
      end
      default: begin
        s3_d.g_fg = ptc_pkg::COL_WHITE;
        s3_d.g_bg = ptc_pkg::COL_GREY;
      end
    endcase
    if (data_i.level == '0) begin
      s3_d.g_glyph = ptc_pkg::GLYPH_SOLID;
      s3_d.g_fg    = ptc_pkg::COL_BLACK;
      s3_d.g_bg    = ptc_pkg::COL_BLACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (ready_o) begin
      s3_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) s3_q <= s3_d;
  end

endmodule

@@ sv/ptc_cell.sv @@
module ptc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  ptc_pkg::s3_t     data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output ptc_pkg::glyph_t  glyph_o,
  output ptc_pkg::colour_t fore_colour_o,
  output ptc_pkg::colour_t back_colour_o
);

  ptc_pkg::glyph_t  glyph_d, glyph_q;
  ptc_pkg::colour_t fg_d, fg_q, bg_d, bg_q;
  ptc_pkg::shade_t  shade;
  ptc_pkg::pair_t   pair;
  logic             valid_q;

  assign ready_o       = !valid_q || ready_i;
  assign valid_o       = valid_q;
  assign glyph_o       = glyph_q;
  assign fore_colour_o = fg_q;
  assign back_colour_o = bg_q;

  // Colors and shade glyph from the winning pairing.
  always_comb begin
    pair  = ptc_pkg::PAIRINGS[data_i.idx];
    shade = ptc_pkg::shade_t'(data_i.c1) + ptc_pkg::SHADE_OFFSET
          - ptc_pkg::shade_t'(data_i.c2);
    if (shade < ptc_pkg::SHADE_Q1)      glyph_d = ptc_pkg::GLYPH_SPACE;
    else if (shade < ptc_pkg::SHADE_Q2) glyph_d = ptc_pkg::GLYPH_QUARTER;
    else if (shade < ptc_pkg::SHADE_Q3) glyph_d = ptc_pkg::GLYPH_HALF;
    else if (shade < ptc_pkg::SHADE_Q4) glyph_d = ptc_pkg::GLYPH_THREEQ;
    else                                glyph_d = ptc_pkg::GLYPH_SOLID;
    fg_d = data_i.c1[7] ? pair.fg_bright : pair.fg_dark;
    if (data_i.flat) begin
      case (data_i.c2[7:6])
        2'd0:    bg_d = ptc_pkg::COL_BLACK;
        2'd1:    bg_d = ptc_pkg::COL_DARK_GREY;
        2'd2:    bg_d = ptc_pkg::COL_GREY;
        default: bg_d = ptc_pkg::COL_WHITE;
      endcase
    end else begin
      bg_d = data_i.c2[7] ? pair.bg_bright : pair.bg_dark;
    end
    // Secondary outweighs primary: half shade on black.
    if (!data_i.colour_set) begin
      glyph_d = ptc_pkg::GLYPH_HALF;
      fg_d    = ptc_pkg::COL_BLACK;
      bg_d    = ptc_pkg::COL_BLACK;
    end
    if (data_i.grey) begin
      glyph_d = data_i.g_glyph;
      fg_d    = data_i.g_fg;
      bg_d    = data_i.g_bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      glyph_q <= glyph_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
    end
  end

endmodule
